[rtl/core/abbl_pkg.sv]
// ---------------------------------------------------------------------------
// ARGB box blur line - shared definitions
// Widths, register map, reset values and the controller/datapath interface.
// ---------------------------------------------------------------------------
package abbl_pkg;

  localparam int MAX_RADIUS_DEF      = 24;
  localparam int MAX_LINE_LENGTH_DEF = 4096;

  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int N_CH       = 4;
  localparam int SUM_W      = 14;
  localparam int RECIP_W    = 31;
  localparam int RADIUS_W   = 5;
  localparam int LEN_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int ROUND_SHIFT = 16;
  localparam int OUT_SHIFT   = 15;
  localparam int ROUND_W     = PROD_W - ROUND_SHIFT + 1;
  localparam int VAL_W       = ROUND_W - OUT_SHIFT;

  localparam logic [ROUND_W-1:0] ROUND_HALF = ROUND_W'(16'h4000);

  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1);
  localparam logic [RECIP_W-1:0]  RECIP_RST  = RECIP_W'(715827883);
  localparam logic [LEN_W-1:0]    LEN_RST    = LEN_W'(640);

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LEN    = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    OP_INIT,
    OP_ADD,
    OP_SLIDE_EDGE,
    OP_SLIDE_MEM
  } sum_op_e;

  typedef struct packed {
    logic    capture;
    logic    rd;
    logic    rd_flush;
    logic    upd;
    logic    fupd;
    sum_op_e op;
    logic    mul;
    logic    emit;
  } abbl_cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic pos_le_r;
    logic pos_ge_r;
    logic pos_ge_2r1;
    logic flush_left;
    logic out_free;
  } abbl_sts_t;

endpackage

[rtl/core/abbl_ram.sv]
// ---------------------------------------------------------------------------
// ARGB box blur line - generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module abbl_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 49,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/abbl_ctrl.sv]
// ---------------------------------------------------------------------------
// ARGB box blur line - controller
// Sequences store read and window update per beat, multiply and result load
// for beats that yield a result, and the tail flush at the end of a line.
// ---------------------------------------------------------------------------
module abbl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  abbl_pkg::abbl_sts_t sts_i,
  output abbl_pkg::abbl_cmd_t cmd_o
);
  import abbl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FUPD = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.rd = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        priority if (sts_i.pos_zero) begin
          cmd_o.op = OP_INIT;
        end else if (sts_i.pos_le_r) begin
          cmd_o.op = OP_ADD;
        end else if (sts_i.pos_ge_2r1) begin
          cmd_o.op = OP_SLIDE_MEM;
        end else begin
          cmd_o.op = OP_SLIDE_EDGE;
        end
        state_d = sts_i.pos_ge_r ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.out_free) begin
          state_d = sts_i.flush_left ? S_FRD : S_IDLE;
        end
      end
      S_FRD: begin
        cmd_o.rd       = 1'b1;
        cmd_o.rd_flush = 1'b1;
        state_d        = S_FUPD;
      end
      S_FUPD: begin
        cmd_o.fupd = 1'b1;
        cmd_o.op   = OP_SLIDE_MEM;
        state_d    = S_MUL;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

endmodule

[rtl/core/abbl_datapath.sv]
// ---------------------------------------------------------------------------
// ARGB box blur line - datapath
// Config registers, line position, window store, channel sums, scaling
// multipliers and the result register.
// ---------------------------------------------------------------------------
module abbl_datapath #(
  parameter int MAX_RADIUS      = abbl_pkg::MAX_RADIUS_DEF,
  parameter int MAX_LINE_LENGTH = abbl_pkg::MAX_LINE_LENGTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  abbl_pkg::abbl_cmd_t               cmd_i,
  output abbl_pkg::abbl_sts_t               sts_o,
  input  logic                              cfg_we_i,
  input  logic [abbl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [abbl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [abbl_pkg::PIX_W-1:0]        pix_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [abbl_pkg::PIX_W-1:0]        out_pix_o,
  output logic                              out_last_o
);
  import abbl_pkg::*;

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int NA_W  = AW + 1;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int LW    = $clog2(MAX_LINE_LENGTH + 1);
  localparam int PW    = $clog2(MAX_LINE_LENGTH);
  localparam int INIT_W = CH_W + RW + 1;

  logic [RADIUS_W-1:0] radius_q;
  logic [RECIP_W-1:0]  recip_q;
  logic [LEN_W-1:0]    len_q;
  logic [PW-1:0]       pos_q;
  logic [AW-1:0]       wr_q;
  logic [AW-1:0]       frd_q;
  logic [RW-1:0]       fcnt_q;
  logic [PIX_W-1:0]    x_q;
  logic [PIX_W-1:0]    edge_q;
  logic                out_valid_q;
  logic [PIX_W-1:0]    out_pix_q;
  logic                out_last_q;

  logic [LW-1:0]   len_eff, half, p_l, r_l, r2p1_l;
  logic [RW-1:0]   r_cap, r;
  logic [RW:0]     r_inc;
  logic            wrap, pos_last, out_free, load_out;
  logic [PW-1:0]   p;
  logic [AW-1:0]   wi, wi_inc, frd_inc, na, fa, raddr;
  logic [NA_W-1:0] na_raw, fa_raw;
  logic [PIX_W-1:0] ram_rdata, old_pix, pix_new;

  // effective length and radius
  always_comb begin
    if (len_q == '0) begin
      len_eff = LW'(1);
    end else if ({1'b0, len_q} > (LEN_W + 1)'(MAX_LINE_LENGTH)) begin
      len_eff = LW'(MAX_LINE_LENGTH);
    end else begin
      len_eff = LW'(len_q);
    end
  end

  assign half  = (len_eff - LW'(1)) >> 1;
  assign r_cap = ({1'b0, radius_q} > (RADIUS_W + 1)'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                                   : RW'(radius_q);
  assign r     = (LW'(r_cap) > half) ? RW'(half) : r_cap;
  assign r_inc = {1'b0, r} + (RW + 1)'(1);

  assign wrap     = (LW'(pos_q) >= len_eff);
  assign p        = wrap ? '0 : pos_q;
  assign wi       = wrap ? '0 : wr_q;
  assign p_l      = LW'(p);
  assign r_l      = LW'(r);
  assign r2p1_l   = LW'({r, 1'b1});
  assign pos_last = (p_l == len_eff - LW'(1));

  // store addresses modulo the store depth
  assign na_raw  = NA_W'(wi) + NA_W'(DEPTH) - NA_W'({r, 1'b1});
  assign na      = (na_raw >= NA_W'(DEPTH)) ? AW'(na_raw - NA_W'(DEPTH)) : AW'(na_raw);
  assign fa_raw  = NA_W'(wi) + NA_W'(DEPTH) - NA_W'({r, 1'b0});
  assign fa      = (fa_raw >= NA_W'(DEPTH)) ? AW'(fa_raw - NA_W'(DEPTH)) : AW'(fa_raw);
  assign wi_inc  = (wi == AW'(DEPTH - 1)) ? '0 : wi + AW'(1);
  assign frd_inc = (frd_q == AW'(DEPTH - 1)) ? '0 : frd_q + AW'(1);
  assign raddr   = cmd_i.rd_flush ? frd_q : na;

  abbl_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i (wi),
    .wdata_i (x_q),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign old_pix = (cmd_i.op == OP_SLIDE_EDGE) ? edge_q : ram_rdata;

  for (genvar c = 0; c < N_CH; c++) begin : g_ch
    logic [CH_W-1:0]    a, o;
    logic [SUM_W-1:0]   sub, sum_d, sum_q;
    logic [SUM_W:0]     acc;
    logic [INIT_W-1:0]  init_v;
    logic [PROD_W-1:0]  prod_q;
    logic [ROUND_W-1:0] rnd;
    logic [VAL_W-1:0]   val;

    always_comb begin
      a      = x_q[c*CH_W +: CH_W];
      o      = old_pix[c*CH_W +: CH_W];
      sub    = (sum_q > SUM_W'(o)) ? sum_q - SUM_W'(o) : '0;
      init_v = INIT_W'(a) * INIT_W'(r_inc);
      unique case (cmd_i.op)
        OP_INIT:                    acc = (SUM_W + 1)'(init_v);
        OP_ADD:                     acc = {1'b0, sum_q} + (SUM_W + 1)'(a);
        OP_SLIDE_EDGE, OP_SLIDE_MEM: acc = {1'b0, sub} + (SUM_W + 1)'(a);
        default:                    acc = {1'b0, sum_q};
      endcase
      sum_d = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sum_q <= '0;
      end else if (cmd_i.upd || cmd_i.fupd) begin
        sum_q <= sum_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul) begin
        prod_q <= PROD_W'(sum_q) * PROD_W'(recip_q);
      end
    end

    assign rnd = ROUND_W'(prod_q[PROD_W-1:ROUND_SHIFT]) + ROUND_HALF;
    assign val = rnd[ROUND_W-1:OUT_SHIFT];
    assign pix_new[c*CH_W +: CH_W] = (|val[VAL_W-1:CH_W]) ? '1 : val[CH_W-1:0];
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      recip_q  <= RECIP_RST;
      len_q    <= LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_RECIP:  recip_q  <= cfg_data_i[RECIP_W-1:0];
        CFG_LEN:    len_q    <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // line position; a radius or length write restarts the line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      wr_q  <= '0;
    end else if (cfg_we_i && (cfg_index_i == CFG_RADIUS || cfg_index_i == CFG_LEN)) begin
      pos_q <= '0;
      wr_q  <= '0;
    end else if (cmd_i.upd) begin
      pos_q <= pos_last ? '0 : p + PW'(1);
      wr_q  <= pos_last ? '0 : wi_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
      frd_q  <= '0;
      edge_q <= '0;
    end else begin
      if (cmd_i.upd) begin
        fcnt_q <= pos_last ? r : '0;
        frd_q  <= fa;
        if (cmd_i.op == OP_INIT) begin
          edge_q <= x_q;
        end
      end else if (cmd_i.fupd) begin
        fcnt_q <= fcnt_q - RW'(1);
        frd_q  <= frd_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q <= pix_i;
    end
  end

  // result register
  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = cmd_i.emit && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pix_q  <= pix_new;
      out_last_q <= (fcnt_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_last_o  = out_last_q;

  assign sts_o.pos_zero   = (p == '0);
  assign sts_o.pos_le_r   = (p_l <= r_l);
  assign sts_o.pos_ge_r   = (p_l >= r_l);
  assign sts_o.pos_ge_2r1 = (p_l >= r2p1_l);
  assign sts_o.flush_left = (fcnt_q != '0);
  assign sts_o.out_free   = out_free;

endmodule

[rtl/core/argb_box_blur_line_top.sv]
// Sequence: input is taken only when idle; a beat that yields a result goes
// through read, update, multiply and load, longer while an earlier result
// waits for m_axis_tready; one that yields none only through read and update.
// Line end: flush read, flush update, multiply, load per flushed result.
// Reset: rst_ni async low clears position, sums, edge pixel and result valid
// and restores register defaults; the window store is not cleared.
// ---------------------------------------------------------------------------
// ARGB box blur line - top level
// Horizontal edge-clamped box blur over a line of packed 32-bit pixels.
// ---------------------------------------------------------------------------
module argb_box_blur_line_top #(
  parameter int MAX_RADIUS      = abbl_pkg::MAX_RADIUS_DEF,
  parameter int MAX_LINE_LENGTH = abbl_pkg::MAX_LINE_LENGTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [abbl_pkg::PIX_W-1:0]      s_axis_tdata,   // [31:0] pixel_in
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [abbl_pkg::PIX_W-1:0]      m_axis_tdata,   // [31:0] pixel_out
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [abbl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [abbl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import abbl_pkg::*;

  abbl_cmd_t cmd;
  abbl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  abbl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  abbl_datapath #(
    .MAX_RADIUS      (MAX_RADIUS),
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_pix_o   (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

[rtl/core/abbl_checker.sv]
// ---------------------------------------------------------------------------
// ARGB box blur line - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
module abbl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [abbl_pkg::PIX_W-1:0] m_axis_tdata,
  input logic                       m_axis_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result beat changed while stalled");

  // one pixel at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

  // no result can be ready the cycle after a pixel is taken
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // mid-flush result pending: input side stays closed
  a_flush_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input open during line flush");

endmodule

bind argb_box_blur_line_top abbl_checker u_abbl_checker (.*);
